// File: rtl/gsz_pkg.sv
// Package for the gas signal z-score index block.
// Holds the sequencer state type and the fixed widths and constants.
// No dependencies.
package gsz_pkg;

    // Fixed field and state widths
    localparam int RAW_IN_W  = 16;   // raw_signal field width
    localparam int MEAN_FRAC = 16;   // fraction bits of the mean
    localparam int CNT_W     = 8;    // sample counter and learning_samples
    localparam int IDX_W     = 9;    // index_value width
    localparam int SUM_W     = 48;   // squared deviation sum, Q40.8
    localparam int VAR_W     = 56;   // variance, Q.16
    localparam int SQ_W      = 28;   // std deviation, Q.8
    localparam int DDW       = 36;   // divisor width (std << 8)

    // Arithmetic constants
    localparam int SUM_RND   = 8388608;  // half of the Q.32 to Q.8 step
    localparam int SUM_SH    = 24;
    localparam int SD_MIN    = 256;      // 1.0 in Q.8
    localparam int Q_CLAMP   = 1000;
    localparam int EMA_MUL   = 999;
    localparam int EMA_DIV   = 1000;
    localparam int EMA_RND   = 500;
    localparam int IDX_SCALE = 100;

    localparam logic [CNT_W-1:0] LS_RESET = 8'd100;
    localparam logic [IDX_W-1:0] NEUTRAL  = 9'd100;
    localparam logic [IDX_W-1:0] IDX_MIN  = 9'd1;
    localparam logic [IDX_W-1:0] IDX_MAX  = 9'd500;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_L_DIV,
        S_L_MUL,
        S_X_VDIV,
        S_X_SQRT,
        S_X_MUL1,
        S_X_QDIV,
        S_X_MUL2,
        S_X_MDIV,
        S_OUT
    } t_state;

endpackage

// File: rtl/gsz_if.sv
// Valid/ready channel interfaces for the sample and result items.
// Depends on gsz_pkg for the field widths.
interface gsz_in_if;
    logic                          valid;
    logic                          ready;
    logic [gsz_pkg::RAW_IN_W-1:0]  raw_sample;
    logic                          restart;

    modport source (output valid, raw_sample, restart, input ready);
    modport sink   (input valid, raw_sample, restart, output ready);
endinterface

interface gsz_out_if;
    logic                        valid;
    logic                        ready;
    logic [gsz_pkg::IDX_W-1:0]   index_value;
    logic                        learning;

    modport source (output valid, index_value, learning, input ready);
    modport sink   (input valid, index_value, learning, output ready);
endinterface

// File: rtl/gsz_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by the gas_signal_zscore_index sequencer.
module gsz_div #(
    parameter int NW = 56,
    parameter int DW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW);

    logic [NW-1:0] r_q, n_q;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   c_sh;
    logic [DW:0]   c_diff;
    logic          c_ge;

    // One restoring step
    always_comb begin
        c_sh   = {r_rem, r_q[NW-1]};
        c_diff = c_sh - {1'b0, r_den};
        c_ge   = (c_sh >= {1'b0, r_den});
        n_rem  = c_ge ? c_diff[DW-1:0] : c_sh[DW-1:0];
        n_q    = {r_q[NW-2:0], c_ge};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: rtl/gsz_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Standalone; used by the gas_signal_zscore_index sequencer.
module gsz_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_prod
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW);

    logic [AW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_acc, n_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    // Shift and conditionally add
    always_comb begin
        n_acc = {r_acc[PW-2:0], 1'b0} + (r_b[BW-1] ? PW'(r_a) : '0);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {r_b[BW-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// File: rtl/gsz_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on gsz_pkg for VAR_W and SQ_W.
module gsz_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gsz_pkg::VAR_W-1:0]  i_val,
    output logic                       o_done,
    output logic [gsz_pkg::SQ_W-1:0]   o_root
);
    localparam int VW = gsz_pkg::VAR_W;
    localparam int RW = gsz_pkg::SQ_W;
    localparam int MW = RW + 2;
    localparam int CW = $clog2(RW);

    logic [VW-1:0] r_val;
    logic [MW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_root, n_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [MW+1:0] c_sh;
    logic [MW+1:0] c_trial;
    logic [MW+1:0] c_diff;
    logic          c_ge;

    // One root digit
    always_comb begin
        c_sh    = {r_rem, r_val[VW-1:VW-2]};
        c_trial = {2'b00, r_root, 2'b01};
        c_diff  = c_sh - c_trial;
        c_ge    = (c_sh >= c_trial);
        n_rem   = c_ge ? c_diff[MW-1:0] : c_sh[MW-1:0];
        n_root  = {r_root[RW-2:0], c_ge};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[VW-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// File: rtl/gas_signal_zscore_index.sv
// Top level: gas signal z-score index sequencer and state.
// Depends on gsz_pkg, gsz_if, gsz_div, gsz_mul and gsz_sqrt.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    raw_sample[15:0], restart
//  o_out    out  valid/ready    index_value[8:0], learning
//  i_cfg    in   write enable   learning_samples[7:0]
//
// One item at a time. A learning sample runs a divide and a multiply; an
// index sample runs three divides, a square root and two multiplies. Every
// divide uses the one shared bit-serial divider. Reset is synchronous and
// needs no clearing pass. A result waits in the output register while the next
// item is accepted; the sequencer stalls at its end only if that register is full.
module gas_signal_zscore_index #(
    parameter int RAW_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gsz_pkg::CNT_W-1:0]  i_cfg_data,
    gsz_in_if.sink                     i_in,
    gsz_out_if.source                  o_out
);
    localparam int MW  = RAW_WIDTH + gsz_pkg::MEAN_FRAC;
    localparam int PW  = 2 * MW;
    localparam int DNW = (MW + 10 > gsz_pkg::VAR_W) ? MW + 10 : gsz_pkg::VAR_W;
    localparam int RXW = (PW + 1 > 72) ? PW + 1 : 72;
    localparam int SW  = gsz_pkg::SUM_W;
    localparam int CW  = gsz_pkg::CNT_W;
    localparam int IW  = gsz_pkg::IDX_W;

    gsz_pkg::t_state r_state, n_state;

    // Architectural state
    logic [CW-1:0] r_ls;
    logic [CW-1:0] r_count;
    logic [MW-1:0] r_mean;
    logic [SW-1:0] r_sum;

    // Working registers
    logic [MW-1:0]               r_raw;
    logic [MW-1:0]               r_mag;
    logic                        r_neg;
    logic [gsz_pkg::SQ_W-1:0]    r_sd;
    logic [IW-1:0]               r_res_index;
    logic                        r_res_learn;

    // Output register
    logic          r_out_valid;
    logic [IW-1:0] r_out_index;
    logic          r_out_learn;

    // Unit connections
    logic                       div_start, div_done;
    logic [DNW-1:0]             div_num, div_quot;
    logic [gsz_pkg::DDW-1:0]    div_den;
    logic                       mul_start, mul_done;
    logic [MW-1:0]              mul_a, mul_b;
    logic [PW-1:0]              mul_prod;
    logic                       sq_start, sq_done;
    logic [gsz_pkg::SQ_W-1:0]   sq_root;

    logic                 c_ready;
    logic                 c_accept;
    logic                 c_out_free;
    logic [RAW_WIDTH-1:0] c_raw_in;
    logic                 c_learn;
    logic                 c_neg;
    logic [MW-1:0]        c_mag;
    logic [CW-1:0]        c_n;
    logic [CW-1:0]        c_vdiv;
    logic [MW-1:0]        c_step;
    logic [MW-1:0]        c_mean_l;
    logic [MW-1:0]        c_d2;
    logic [RXW-1:0]       c_rnd;
    logic [RXW-1:0]       c_shr;
    logic [SW-1:0]        c_add;
    logic [SW:0]          c_sumx;
    logic [SW-1:0]        c_sum_n;
    logic [gsz_pkg::SQ_W-1:0] c_sd;
    logic [9:0]           c_qc;
    logic signed [11:0]   c_idx_raw;
    logic [IW-1:0]        c_idx;

    gsz_div #(.NW(DNW), .DW(gsz_pkg::DDW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    gsz_mul #(.AW(MW), .BW(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    gsz_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (div_quot[gsz_pkg::VAR_W-1:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Datapath arithmetic between unit steps
    always_comb begin
        c_raw_in = RAW_WIDTH'(i_in.raw_sample);
        c_learn  = (r_count < r_ls);
        c_neg    = (r_raw < r_mean);
        c_mag    = c_neg ? (r_mean - r_raw) : (r_raw - r_mean);
        c_n      = r_count + 1'b1;
        c_vdiv   = (r_count > CW'(1)) ? (r_count - 1'b1) : CW'(1);
        // learning: mean step and second deviation
        c_step   = div_quot[MW-1:0];
        c_mean_l = r_neg ? (r_mean - c_step) : (r_mean + c_step);
        c_d2     = r_mag - c_step;
        // Q.32 product rounded to Q.8, then saturating accumulate
        c_rnd    = RXW'(mul_prod) + RXW'(gsz_pkg::SUM_RND);
        c_shr    = c_rnd >> gsz_pkg::SUM_SH;
        c_add    = (|c_shr[RXW-1:SW]) ? {SW{1'b1}} : c_shr[SW-1:0];
        c_sumx   = {1'b0, r_sum} + {1'b0, c_add};
        c_sum_n  = c_sumx[SW] ? {SW{1'b1}} : c_sumx[SW-1:0];
        // std floor of 1.0
        c_sd     = (sq_root < gsz_pkg::SQ_W'(gsz_pkg::SD_MIN))
                   ? gsz_pkg::SQ_W'(gsz_pkg::SD_MIN) : sq_root;
        // z offset, clamped, then index saturation
        c_qc     = (div_quot > DNW'(gsz_pkg::Q_CLAMP))
                   ? 10'(gsz_pkg::Q_CLAMP) : div_quot[9:0];
        c_idx_raw = r_neg ? (12'sd100 - $signed({2'b00, c_qc}))
                          : (12'sd100 + $signed({2'b00, c_qc}));
        if (c_idx_raw < 12'sd1) begin
            c_idx = gsz_pkg::IDX_MIN;
        end else if (c_idx_raw > 12'sd500) begin
            c_idx = gsz_pkg::IDX_MAX;
        end else begin
            c_idx = c_idx_raw[IW-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gsz_pkg::S_IDLE:   if (i_in.valid) n_state = gsz_pkg::S_DECIDE;
            gsz_pkg::S_DECIDE: n_state = c_learn ? gsz_pkg::S_L_DIV : gsz_pkg::S_X_VDIV;
            gsz_pkg::S_L_DIV:  if (div_done) n_state = gsz_pkg::S_L_MUL;
            gsz_pkg::S_L_MUL:  if (mul_done) n_state = gsz_pkg::S_OUT;
            gsz_pkg::S_X_VDIV: if (div_done) n_state = gsz_pkg::S_X_SQRT;
            gsz_pkg::S_X_SQRT: if (sq_done)  n_state = gsz_pkg::S_X_MUL1;
            gsz_pkg::S_X_MUL1: if (mul_done) n_state = gsz_pkg::S_X_QDIV;
            gsz_pkg::S_X_QDIV: if (div_done) n_state = gsz_pkg::S_X_MUL2;
            gsz_pkg::S_X_MUL2: if (mul_done) n_state = gsz_pkg::S_X_MDIV;
            gsz_pkg::S_X_MDIV: if (div_done) n_state = gsz_pkg::S_OUT;
            gsz_pkg::S_OUT:    if (c_out_free) n_state = gsz_pkg::S_IDLE;
            default:           n_state = gsz_pkg::S_IDLE;
        endcase
    end

    // Control outputs and unit operands
    always_comb begin
        c_ready    = (r_state == gsz_pkg::S_IDLE);
        c_accept   = c_ready && i_in.valid;
        c_out_free = !r_out_valid || o_out.ready;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        sq_start   = 1'b0;
        unique case (r_state)
            gsz_pkg::S_DECIDE: begin
                div_start = 1'b1;
                if (c_learn) begin
                    div_num = DNW'(c_mag) + DNW'(c_n >> 1);
                    div_den = gsz_pkg::DDW'(c_n);
                end else begin
                    div_num = DNW'({r_sum, 8'h00});
                    div_den = gsz_pkg::DDW'(c_vdiv);
                end
            end
            gsz_pkg::S_L_DIV: begin
                mul_start = div_done;
                mul_a     = r_mag;
                mul_b     = c_d2;
            end
            gsz_pkg::S_X_VDIV: begin
                sq_start = div_done;
            end
            gsz_pkg::S_X_SQRT: begin
                mul_start = sq_done;
                mul_a     = r_mag;
                mul_b     = MW'(gsz_pkg::IDX_SCALE);
            end
            gsz_pkg::S_X_MUL1: begin
                div_start = mul_done;
                div_num   = DNW'(mul_prod[MW+6:0]);
                div_den   = {r_sd, 8'h00};
            end
            gsz_pkg::S_X_QDIV: begin
                mul_start = div_done;
                mul_a     = r_mean;
                mul_b     = MW'(gsz_pkg::EMA_MUL);
            end
            gsz_pkg::S_X_MUL2: begin
                div_start = mul_done;
                div_num   = DNW'(mul_prod[MW+9:0]) + DNW'(r_raw)
                          + DNW'(gsz_pkg::EMA_RND);
                div_den   = gsz_pkg::DDW'(gsz_pkg::EMA_DIV);
            end
            default: begin
            end
        endcase
    end

    // State, architectural registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gsz_pkg::S_IDLE;
            r_ls        <= gsz_pkg::LS_RESET;
            r_count     <= '0;
            r_mean      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_ls <= i_cfg_data;
            end
            // restart flag clears the learned state on accept
            if (c_accept && i_in.restart) begin
                r_count <= '0;
                r_mean  <= '0;
                r_sum   <= '0;
            end
            if (r_state == gsz_pkg::S_DECIDE && c_learn) begin
                r_count <= c_n;
            end
            if (r_state == gsz_pkg::S_L_DIV && div_done) begin
                r_mean <= c_mean_l;
            end
            if (r_state == gsz_pkg::S_L_MUL && mul_done) begin
                r_sum <= c_sum_n;
            end
            if (r_state == gsz_pkg::S_X_MDIV && div_done) begin
                r_mean <= div_quot[MW-1:0];
            end
            // output register
            if (r_state == gsz_pkg::S_OUT && c_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_raw <= {c_raw_in, {gsz_pkg::MEAN_FRAC{1'b0}}};
        end
        if (r_state == gsz_pkg::S_DECIDE) begin
            r_neg <= c_neg;
            r_mag <= c_mag;
        end
        if (r_state == gsz_pkg::S_L_MUL && mul_done) begin
            r_res_index <= gsz_pkg::NEUTRAL;
            r_res_learn <= 1'b1;
        end
        if (r_state == gsz_pkg::S_X_SQRT && sq_done) begin
            r_sd <= c_sd;
        end
        if (r_state == gsz_pkg::S_X_QDIV && div_done) begin
            r_res_index <= c_idx;
            r_res_learn <= 1'b0;
        end
        if (r_state == gsz_pkg::S_OUT && c_out_free) begin
            r_out_index <= r_res_index;
            r_out_learn <= r_res_learn;
        end
    end

    assign i_in.ready        = c_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.index_value = r_out_index;
    assign o_out.learning    = r_out_learn;

`ifndef SYNTHESIS
    // accepted item always goes to the decision step
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_accept |=> (r_state == gsz_pkg::S_DECIDE))
        else $error("accepted item did not enter decide");

    // learning results carry the neutral index
    a_learn_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_learn) |-> (r_out_index == gsz_pkg::NEUTRAL))
        else $error("learning result not neutral");

    // index results lie in the saturation range
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_learn) |->
            (r_out_index >= gsz_pkg::IDX_MIN && r_out_index <= gsz_pkg::IDX_MAX))
        else $error("index out of range");

    // divider finishes only where the sequencer waits on it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == gsz_pkg::S_L_DIV || r_state == gsz_pkg::S_X_VDIV ||
                      r_state == gsz_pkg::S_X_QDIV || r_state == gsz_pkg::S_X_MDIV))
        else $error("divider done in wrong state");

    // std floor holds once the root is taken
    a_sd_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gsz_pkg::S_X_MUL1) |->
            (r_sd >= gsz_pkg::SQ_W'(gsz_pkg::SD_MIN)))
        else $error("std below floor");
`endif

endmodule
